// ===== sv/shkd_pkg.sv =====
// ----------------------------------------------------------------------------
// shkd_pkg
// Shared constants and types for the string key hash directory.
// ----------------------------------------------------------------------------
package shkd_pkg;

    localparam int TABLE_SLOTS_DEF = 64;
    localparam int MAX_NAME_DEF    = 32;

    localparam int HASH_WEIGHT = 29;
    localparam int CHAR_W      = 8;

    localparam int SLOT_OUT_W = 6;
    localparam int ENTRY_W    = 24;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_TOO_LONG  = 2'd3
    } t_status;

endpackage

// ===== sv/shkd_ram.sv =====
// ----------------------------------------------------------------------------
// shkd_ram
// Generic simple dual port RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
module shkd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/shkd_hash.sv =====
// ----------------------------------------------------------------------------
// shkd_hash
// Hash update (acc + char * 29) mod TABLE_SLOTS, registered; the product
// residues come from a constant table indexed by the key byte.
// ----------------------------------------------------------------------------
module shkd_hash #(
    parameter int TABLE_SLOTS = shkd_pkg::TABLE_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [shkd_pkg::CHAR_W-1:0]    i_char,
    input  logic [$clog2(TABLE_SLOTS)-1:0] i_acc,
    output logic                           o_done,
    output logic [$clog2(TABLE_SLOTS)-1:0] o_acc
);
    import shkd_pkg::*;

    localparam int SW = $clog2(TABLE_SLOTS);

    logic [SW-1:0] w_prod [1 << CHAR_W];
    logic          r_done;
    logic [SW-1:0] r_acc, n_acc;
    logic [SW:0]   w_s;

    for (genvar g = 0; g < (1 << CHAR_W); g++) begin : g_prod
        assign w_prod[g] = SW'((g * HASH_WEIGHT) % TABLE_SLOTS);
    end

    always_comb begin
        w_s = {1'b0, i_acc} + {1'b0, w_prod[i_char]};
        if (w_s >= (SW+1)'(TABLE_SLOTS)) begin
            w_s = w_s - (SW+1)'(TABLE_SLOTS);
        end
        n_acc = r_acc;
        if (i_start) begin
            n_acc = w_s[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

// ===== sv/string_key_hash_directory_top.sv =====
// ----------------------------------------------------------------------------
// string_key_hash_directory_top
// File directory keyed by name strings, open addressing, quadratic probing.
//
//  channel  dir  tdata (low bit up)                          tlast     tuser
//  s_axis   in   key_char[7:0] entry_type[9:8] entry_size    key_last  req_type
//                [33:10] entry_address[57:34] entry_deleted[58]
//  m_axis   out  slot_index[5:0] status[7:6]                 -         -
//
//  Each key byte is accepted, then goes through the table-driven hash update;
//  a dropped overlong byte is only accepted.
//  The last byte adds a finish step, each probe a slot metadata RAM read and
//  check, each compared byte on lookup a read and compare, each copied byte on
//  insert a read and write, and a final step loads the result.
//  After reset a clearing pass writes every slot and empties the table.
//  A pending result does not block new key bytes; only the next result waits.
// ----------------------------------------------------------------------------
module string_key_hash_directory_top #(
    parameter int TABLE_SLOTS = shkd_pkg::TABLE_SLOTS_DEF,
    parameter int MAX_NAME    = shkd_pkg::MAX_NAME_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // key_char, entry_type, entry_size, entry_address, entry_deleted
    input  logic [63:0] i_s_axis_tdata,
    input  logic        i_s_axis_tlast,
    // req_type
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // slot_index, status
    output logic [7:0]  o_m_axis_tdata
);
    import shkd_pkg::*;

    localparam int SW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int NW = $clog2(MAX_NAME);
    localparam int LW = $clog2(MAX_NAME + 1);
    localparam int MW = 2 + LW + ENTRY_W + ENTRY_W + 1;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_HASH  = 11'b00000000100,
        S_FIN   = 11'b00000001000,
        S_PRD   = 11'b00000010000,
        S_PCHK  = 11'b00000100000,
        S_CPR   = 11'b00001000000,
        S_CPW   = 11'b00010000000,
        S_CMR   = 11'b00100000000,
        S_CMC   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state               r_state, n_state;
    logic [SW-1:0]        r_clr, n_clr;
    logic [LW-1:0]        r_len, n_len;
    logic [SW-1:0]        r_acc, n_acc;
    logic                 r_ovf, n_ovf;
    logic                 r_req, n_req;
    logic                 r_last, n_last;
    logic [1:0]           r_etype, n_etype;
    logic [ENTRY_W-1:0]   r_esize, n_esize;
    logic [ENTRY_W-1:0]   r_eaddr, n_eaddr;
    logic                 r_edel, n_edel;
    logic [SW-1:0]        r_slot, n_slot;
    logic [SW-1:0]        r_d, n_d;
    logic [CW-1:0]        r_i, n_i;
    logic [LW-1:0]        r_j, n_j;
    logic [SW-1:0]        r_rslot, n_rslot;
    t_status              r_rstat, n_rstat;
    logic                 r_ovalid, n_ovalid;
    logic [SW-1:0]        r_oslot, n_oslot;
    t_status              r_ostat, n_ostat;

    logic                 w_acc_in;
    logic                 w_hstart;
    logic                 w_hdone;
    logic [SW-1:0]        w_hacc;
    logic                 w_kwe;
    logic [7:0]           w_krd;
    logic                 w_nwe;
    logic [7:0]           w_nrd;
    logic                 w_mwe;
    logic [SW-1:0]        w_mwaddr;
    logic [MW-1:0]        w_mwdata;
    logic [MW-1:0]        w_mrd;
    logic [1:0]           w_mkind;
    logic [LW-1:0]        w_mlen;
    logic [SW:0]          w_sn;
    logic [SW:0]          w_dn;
    logic [CW-1:0]        w_inext;
    logic [31:0]          w_oslot32;

    assign w_acc_in        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_mkind         = w_mrd[1:0];
    assign w_mlen          = w_mrd[2 +: LW];

    shkd_hash #(.TABLE_SLOTS(TABLE_SLOTS)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hstart),
        .i_char  (i_s_axis_tdata[7:0]),
        .i_acc   (r_acc),
        .o_done  (w_hdone),
        .o_acc   (w_hacc)
    );

    shkd_ram #(.WIDTH(8), .DEPTH(1 << NW)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_kwe),
        .i_waddr (r_len[NW-1:0]),
        .i_wdata (i_s_axis_tdata[7:0]),
        .i_raddr (r_j[NW-1:0]),
        .o_rdata (w_krd)
    );

    shkd_ram #(.WIDTH(8), .DEPTH(TABLE_SLOTS << NW)) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (w_nwe),
        .i_waddr ({r_slot, r_j[NW-1:0]}),
        .i_wdata (w_krd),
        .i_raddr ({r_slot, r_j[NW-1:0]}),
        .o_rdata (w_nrd)
    );

    shkd_ram #(.WIDTH(MW), .DEPTH(TABLE_SLOTS)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (w_mwe),
        .i_waddr (w_mwaddr),
        .i_wdata (w_mwdata),
        .i_raddr (r_slot),
        .o_rdata (w_mrd)
    );

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_len    = r_len;
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_req    = r_req;
        n_last   = r_last;
        n_etype  = r_etype;
        n_esize  = r_esize;
        n_eaddr  = r_eaddr;
        n_edel   = r_edel;
        n_slot   = r_slot;
        n_d      = r_d;
        n_i      = r_i;
        n_j      = r_j;
        n_rslot  = r_rslot;
        n_rstat  = r_rstat;
        n_ovalid = r_ovalid;
        n_oslot  = r_oslot;
        n_ostat  = r_ostat;
        w_hstart = 1'b0;
        w_kwe    = 1'b0;
        w_nwe    = 1'b0;
        w_mwe    = 1'b0;
        w_mwaddr = r_slot;
        w_mwdata = {r_edel, r_eaddr, r_esize, r_len, r_etype};

        w_sn = {1'b0, r_slot} + {1'b0, r_d};
        if (w_sn >= (SW+1)'(TABLE_SLOTS)) begin
            w_sn = w_sn - (SW+1)'(TABLE_SLOTS);
        end
        w_dn = {1'b0, r_d} + (SW+1)'(2);
        if (w_dn >= (SW+1)'(TABLE_SLOTS)) begin
            w_dn = w_dn - (SW+1)'(TABLE_SLOTS);
        end
        w_inext = r_i + 1'b1;

        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_mwe    = 1'b1;
                w_mwaddr = r_clr;
                w_mwdata = '0;
                n_clr    = r_clr + 1'b1;
                if (r_clr == SW'(TABLE_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_acc_in) begin
                    n_req   = i_s_axis_tuser;
                    n_last  = i_s_axis_tlast;
                    n_etype = i_s_axis_tdata[9:8];
                    n_esize = i_s_axis_tdata[33:10];
                    n_eaddr = i_s_axis_tdata[57:34];
                    n_edel  = i_s_axis_tdata[58];
                    if (r_len < LW'(MAX_NAME)) begin
                        w_kwe    = 1'b1;
                        n_len    = r_len + 1'b1;
                        w_hstart = 1'b1;
                        n_state  = S_HASH;
                    end else begin
                        n_ovf = 1'b1;
                        if (i_s_axis_tlast) begin
                            n_state = S_FIN;
                        end
                    end
                end
            end
            S_HASH: begin
                if (w_hdone) begin
                    n_acc   = w_hacc;
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (r_ovf) begin
                    n_rslot = '0;
                    n_rstat = ST_TOO_LONG;
                    n_state = S_OUT;
                end else begin
                    n_slot  = r_acc;
                    n_d     = SW'(1);
                    n_i     = '0;
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                n_state = S_PCHK;
            end
            S_PCHK: begin
                if (!r_req && w_mkind == 2'd0) begin
                    w_mwe   = 1'b1;
                    n_j     = '0;
                    n_state = S_CPR;
                end else if (r_req && w_mkind != 2'd0 && w_mlen == r_len) begin
                    n_j     = '0;
                    n_state = S_CMR;
                end else begin
                    n_i = w_inext;
                    if (w_inext == CW'(TABLE_SLOTS)) begin
                        n_rslot = '0;
                        n_rstat = r_req ? ST_NOT_FOUND : ST_FULL;
                        n_state = S_OUT;
                    end else begin
                        n_slot  = w_sn[SW-1:0];
                        n_d     = w_dn[SW-1:0];
                        n_state = S_PRD;
                    end
                end
            end
            S_CPR: begin
                n_state = S_CPW;
            end
            S_CPW: begin
                w_nwe = 1'b1;
                n_j   = r_j + 1'b1;
                if (r_j + 1'b1 == r_len) begin
                    n_rslot = r_slot;
                    n_rstat = ST_OK;
                    n_state = S_OUT;
                end else begin
                    n_state = S_CPR;
                end
            end
            S_CMR: begin
                n_state = S_CMC;
            end
            S_CMC: begin
                if (w_krd != w_nrd) begin
                    n_i = w_inext;
                    if (w_inext == CW'(TABLE_SLOTS)) begin
                        n_rslot = '0;
                        n_rstat = ST_NOT_FOUND;
                        n_state = S_OUT;
                    end else begin
                        n_slot  = w_sn[SW-1:0];
                        n_d     = w_dn[SW-1:0];
                        n_state = S_PRD;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                    if (r_j + 1'b1 == r_len) begin
                        n_rslot = r_slot;
                        n_rstat = ST_OK;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_CMR;
                    end
                end
            end
            S_OUT: begin
                n_len = '0;
                n_acc = '0;
                n_ovf = 1'b0;
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_oslot  = r_rslot;
                    n_ostat  = r_rstat;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_len    <= '0;
            r_acc    <= '0;
            r_ovf    <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_len    <= n_len;
            r_acc    <= n_acc;
            r_ovf    <= n_ovf;
            r_i      <= n_i;
            r_j      <= n_j;
            r_ovalid <= n_ovalid;
        end
        r_req   <= n_req;
        r_last  <= n_last;
        r_etype <= n_etype;
        r_esize <= n_esize;
        r_eaddr <= n_eaddr;
        r_edel  <= n_edel;
        r_slot  <= n_slot;
        r_d     <= n_d;
        r_rslot <= n_rslot;
        r_rstat <= n_rstat;
        r_oslot <= n_oslot;
        r_ostat <= n_ostat;
    end

    assign w_oslot32       = 32'(r_oslot);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_ostat, w_oslot32[SLOT_OUT_W-1:0]};

endmodule
